/* rtl/swm_pkg.sv */
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 33;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

  // per-cell control, driven from the window controller
  typedef struct packed {
    logic en;          // a request is taken this cycle
    logic occ;         // cell holds a window sample
    logic below_prev;  // left neighbour lies before the removed slot
    logic below_here;  // this cell lies before the removed slot
    logic bound;       // last position of the window after the update
  } swm_ctl_t;

endpackage

`default_nettype wire

/* rtl/sliding_window_median.sv */
// Sliding-window median, doubled: one request per cycle unless the output stalls.
// A request passes the cell update, the median select, then the 33-bit add into
// the output register; the row of sorting cells updates together on each request.
// Throughput: one request per clock unless the output stalls.
// Reset (rst, synchronous): window emptied, window_size back to 3, no results pending.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX = 64
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                              start_req,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed      [swm_pkg::OUT_W-1:0]  median_doubled,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic        [swm_pkg::CFG_W-1:0]  window_size
);
  import swm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WW = (CW > CFG_W) ? CW : CFG_W;

  // configuration and window occupancy
  logic [CFG_W-1:0] wsize;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_eff;
  logic [CW-1:0]    w_act;
  logic [WW-1:0]    w_ext;
  logic [CW-1:0]    bound_pos;
  logic             full;
  logic             has_result;
  logic             accept;

  // cell row
  logic signed [SAMPLE_W-1:0] vals [WINDOW_MAX];
  logic        [AW-1:0]       ages [WINDOW_MAX];
  logic        [WINDOW_MAX-1:0] gts;
  logic        [WINDOW_MAX-1:0] rm;
  logic        [WINDOW_MAX-1:0] below;
  logic        [AW-1:0]       rm_idx;
  swm_ctl_t                   ctl [WINDOW_MAX];

  // result pipeline
  logic                       sel_pend;
  logic                       sum_pend;
  logic                       sel_move;
  logic                       sum_free;
  logic                       out_move;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  logic        [AW-1:0]       lo_idx;
  logic        [AW-1:0]       hi_idx;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // clamp the window size to 1..WINDOW_MAX
  always_comb begin
    w_ext = WW'(wsize);
    if (w_ext == '0) begin
      w_ext = WW'(1);
    end else if (w_ext > WW'(WINDOW_MAX)) begin
      w_ext = WW'(WINDOW_MAX);
    end
  end
  assign w_act = w_ext[CW-1:0];

  // start request empties the window before the sample goes in
  assign fill_eff   = start_req ? '0 : fill;
  assign full       = (fill_eff == w_act);
  assign has_result = full || ((fill_eff + CW'(1)) == w_act);
  assign bound_pos  = full ? (fill_eff - CW'(1)) : fill_eff;

  // the oldest sample is the occupied cell whose age has reached w-1;
  // cells past the window hold stale ages and never count
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      rm[i] = full && (CW'(i) < fill_eff) && (CW'(ages[i]) == (w_act - CW'(1)));
    end
  end

  always_comb begin
    rm_idx = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (rm[i]) begin
        rm_idx = rm_idx | AW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      below[i] = !full || (AW'(i) < rm_idx);
    end
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic signed [SAMPLE_W-1:0] v_prev;
    logic        [AW-1:0]       a_prev;
    logic                       t_prev;
    logic signed [SAMPLE_W-1:0] v_next;
    logic        [AW-1:0]       a_next;
    logic                       t_next;

    if (g == 0) begin : g_first
      assign v_prev = '0;
      assign a_prev = '0;
      assign t_prev = 1'b0;
    end else begin : g_mid
      assign v_prev = vals[g-1];
      assign a_prev = ages[g-1];
      assign t_prev = gts[g-1];
    end

    if (g == WINDOW_MAX - 1) begin : g_last
      assign v_next = '0;
      assign a_next = '0;
      assign t_next = 1'b0;
    end else begin : g_inner
      assign v_next = vals[g+1];
      assign a_next = ages[g+1];
      assign t_next = gts[g+1];
    end

    assign ctl[g].en         = accept;
    assign ctl[g].occ        = CW'(g) < fill_eff;
    assign ctl[g].below_prev = (g == 0) ? 1'b1 : below[(g == 0) ? 0 : g - 1];
    assign ctl[g].below_here = below[g];
    assign ctl[g].bound      = CW'(g) == bound_pos;

    swm_cell #(
      .AW (AW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .sample   (sample),
      .val_prev (v_prev),
      .age_prev (a_prev),
      .gt_prev  (t_prev),
      .val_next (v_next),
      .age_next (a_next),
      .gt_next  (t_next),
      .val      (vals[g]),
      .age      (ages[g]),
      .gt       (gts[g])
    );
  end

  // middle positions of the sorted row
  assign lo_idx = AW'((w_act - CW'(1)) >> 1);
  assign hi_idx = AW'(w_act >> 1);

  // advance the result through select and add; hold when the output stalls
  assign out_move = sum_pend && (!out_valid || out_ready);
  assign sum_free = !sum_pend || out_move;
  assign sel_move = sel_pend && sum_free;
  assign in_ready = !sel_pend || sum_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      wsize     <= WIN_RESET;
      fill      <= '0;
      sel_pend  <= 1'b0;
      sum_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wsize <= window_size;
        fill  <= '0;
      end else if (accept) begin
        fill <= full ? fill_eff : fill_eff + CW'(1);
      end
      sel_pend  <= (accept && has_result) || (sel_pend && !sum_free);
      sum_pend  <= sel_move || (sum_pend && !out_move);
      out_valid <= out_move || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (sel_move) begin
      lo <= vals[lo_idx];
      hi <= vals[hi_idx];
    end
    if (out_move) begin
      median_doubled <= {lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi};
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= w_act)
    else $error("window fill beyond window size");

  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |-> $onehot(rm))
    else $error("full window without a single oldest sample");

  a_hold_cells: assert property (@(posedge clk) disable iff (rst)
    (sel_pend && !sum_free) |-> !in_ready)
    else $error("request taken while the median select is stalled");

  a_full_steady: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> (fill == $past(fill_eff)))
    else $error("fill changed on a full window");
`endif

endmodule

`default_nettype wire

/* rtl/swm_cell.sv */
`default_nettype none

module swm_cell #(
  parameter int AW = 6
) (
  input  wire                                   clk,
  input  wire swm_pkg::swm_ctl_t                ctl,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] val_prev,
  input  wire logic        [AW-1:0]             age_prev,
  input  wire logic                             gt_prev,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] val_next,
  input  wire logic        [AW-1:0]             age_next,
  input  wire logic                             gt_next,
  output logic signed      [swm_pkg::SAMPLE_W-1:0] val,
  output logic             [AW-1:0]             age,
  output logic                                  gt
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] lval_prev;
  logic signed [SAMPLE_W-1:0] lval_here;
  logic        [AW-1:0]       lage_prev;
  logic        [AW-1:0]       lage_here;
  logic                       lgt_prev;
  logic                       lgt_here;
  logic signed [SAMPLE_W-1:0] val_next_w;
  logic        [AW-1:0]       age_next_w;

  assign gt = ctl.occ && (val > sample);

  // close the gap left by the removed entry
  assign lval_prev = ctl.below_prev ? val_prev : val;
  assign lage_prev = ctl.below_prev ? age_prev : age;
  assign lgt_prev  = ctl.below_prev ? gt_prev  : gt;
  assign lval_here = ctl.below_here ? val      : val_next;
  assign lage_here = ctl.below_here ? age      : age_next;
  assign lgt_here  = ctl.below_here ? gt       : gt_next;

  // then open a gap for the new sample
  always_comb begin
    if (lgt_prev) begin
      val_next_w = lval_prev;
      age_next_w = lage_prev + AW'(1);
    end else if (lgt_here || ctl.bound) begin
      val_next_w = sample;
      age_next_w = '0;
    end else begin
      val_next_w = lval_here;
      age_next_w = lage_here + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val <= val_next_w;
      age <= age_next_w;
    end
  end

endmodule

`default_nettype wire

/* dv/median_check.sv */
`timescale 1ns / 100ps

module median_check #(
  parameter int WINDOW_MAX = 64
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  input  wire                                    in_ready,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                              start_req,
  input  wire                                    out_valid,
  input  wire                                    out_ready,
  input  wire logic signed [swm_pkg::OUT_W-1:0]  median_doubled,
  input  wire                                    cfg_valid,
  input  wire                                    cfg_ready,
  input  wire logic        [swm_pkg::CFG_W-1:0]  window_size,
  output int                                     errors,
  output int                                     medians_pending,
  output int                                     medians_checked
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] ring_q   [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sorted_q [WINDOW_MAX];
  int unsigned                fill;
  int unsigned                oldest;
  logic        [CFG_W-1:0]    win_reg;
  logic signed [OUT_W-1:0]    medians_due [$];
  logic signed [OUT_W-1:0]    want;

  // Take one sample into the window; queue the doubled median once full.
  task automatic slide_window(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    int unsigned             w;
    int unsigned             p;
    int unsigned             i;
    int unsigned             pos;
    logic signed [OUT_W-1:0] lo_v;
    logic signed [OUT_W-1:0] hi_v;
    if (restart) begin
      fill   = 0;
      oldest = 0;
    end
    w = win_reg;
    if (w < 1) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    if (fill == w) begin
      // drop one sorted entry equal to the oldest sample
      p   = oldest % w;
      pos = 0;
      while (pos < fill && sorted_q[pos] != ring_q[p]) pos++;
      for (i = pos; i + 1 < fill; i++) sorted_q[i] = sorted_q[i + 1];
      fill--;
      ring_q[p] = s;
      oldest    = (p + 1) % w;
    end else begin
      ring_q[fill] = s;
    end
    pos = 0;
    while (pos < fill && sorted_q[pos] <= s) pos++;
    for (i = fill; i > pos; i--) sorted_q[i] = sorted_q[i - 1];
    sorted_q[pos] = s;
    fill++;
    if (fill == w) begin
      lo_v = sorted_q[(w - 1) / 2];
      hi_v = sorted_q[w / 2];
      medians_due.insert(medians_due.size(), lo_v + hi_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill    = 0;
      oldest  = 0;
      win_reg = WIN_RESET;
      medians_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (medians_due.size() == 0) begin
          errors++;
          $display("%0t: median %0d with none expected", $time, median_doubled);
        end else begin
          want = medians_due.pop_front();
          medians_checked++;
          if (median_doubled !== want) begin
            errors++;
            $display("%0t: median_doubled expected %0d, got %0d",
                     $time, want, median_doubled);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        win_reg = window_size;
        fill    = 0;
        oldest  = 0;
      end
      if (in_valid && in_ready) slide_window(sample, start_req);
    end
    medians_pending <= medians_due.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import swm_pkg::*;

  localparam int WIN_MAX    = 64;
  // cycles with no request moving on any channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                       clk;
  logic                       rst            = 1'b1;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample         = '0;
  logic                       start_req      = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic signed [OUT_W-1:0]    median_doubled;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  logic        [CFG_W-1:0]    window_size    = WIN_RESET;

  idle_mode_t idle_mode = IDLE_NONE;
  int         errors;
  int         medians_pending;
  int         medians_checked;
  int         samples_sent;
  int         settings_used;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  sliding_window_median #(
    .WINDOW_MAX(WIN_MAX)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .start_req     (start_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .median_doubled(median_doubled),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .window_size   (window_size)
  );

  median_check #(
    .WINDOW_MAX(WIN_MAX)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .start_req      (start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .median_doubled (median_doubled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_size    (window_size),
    .errors         (errors),
    .medians_pending(medians_pending),
    .medians_checked(medians_checked)
  );

  // Result side: stall at the rate of the current idling pattern.
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ready <= ($urandom_range(99) >= 57);
      IDLE_BOTH: out_ready <= ($urandom_range(99) >= 25);
      default:   out_ready <= 1'b1;
    endcase
  end

  // Watchdog: count cycles in which no request moves anywhere.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Full-range samples half of the time, with the extremes and a narrow band near zero
  // so that ties in the sorted window turn up often.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $urandom_range(8) - 4;
      default: return $urandom();
    endcase
  endfunction

  // Present one sample request and hold it until it is taken. Gaps are made
  // by lowering valid first, so valid never drops and rises in one step.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 57 : ((idle_mode == IDLE_BOTH) ? 25 : 0);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    start_req <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid, wait for every expected median, then let the pipeline empty:
  // samples that fill the window give no median but may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (medians_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    cfg_valid   <= 1'b1;
    window_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [CFG_W-1:0] fixed_sizes [8];
    logic [CFG_W-1:0] w;
    int               eff;
    int               n;
    // zero acts as one, anything past the maximum acts as the maximum
    fixed_sizes = '{7'd4, 7'd64, 7'd1, 7'd2, 7'd127, 7'd7, 7'd0, 7'd65};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window of three: extremes, sums across sign, a run of ties.
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    // restart mid-stream: two quiet samples, then the window refills
    push_sample(9, 1'b1);
    push_sample(-9, 1'b0);
    push_sample(3, 1'b0);

    // Size zero behaves as a window of one: every sample is its own median.
    settle();
    write_window(7'd0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(0, 1'b0);

    // Even window: the two middle values are summed, extremes included.
    settle();
    write_window(7'd2);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);

    // Random phases: each rewrites the window and rotates the idling pattern.
    // Restarts are rarer for wide windows so that they still fill.
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      w = (ph < 8) ? fixed_sizes[ph] : CFG_W'($urandom_range(1, 12));
      write_window(w);
      idle_mode = idle_mode_t'(ph % 4);
      eff = (w == 0) ? 1 : ((w > WIN_MAX) ? WIN_MAX : int'(w));
      n   = (eff > 16) ? 160 : 60;
      repeat (n) push_sample(draw_sample(), $urandom_range(0, 4 * eff + 20) == 0);
    end

    settle();
    $display("%0d samples over %0d window settings and four idling patterns",
             samples_sent, settings_used);
    $display("%0d doubled medians compared", medians_checked);
    if (errors == 0 && medians_pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
